### rtl/core/vtu_pkg.sv
`timescale 1ns / 1ps
package vtu_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DIV_STEPS     = 32;
  localparam int NUM_STAGES    = DIV_STEPS + 3;

  localparam logic [3:0] FN_ROTX    = 4'd0;
  localparam logic [3:0] FN_ROTY    = 4'd1;
  localparam logic [3:0] FN_ROTZ    = 4'd2;
  localparam logic [3:0] FN_MOVEX   = 4'd3;
  localparam logic [3:0] FN_MOVEY   = 4'd4;
  localparam logic [3:0] FN_MOVEZ   = 4'd5;
  localparam logic [3:0] FN_ZOOM    = 4'd6;
  localparam logic [3:0] FN_CENTRAL = 4'd7;

  localparam logic [2:0] REG_COS    = 3'd0;
  localparam logic [2:0] REG_SIN    = 3'd1;
  localparam logic [2:0] REG_OFFSET = 3'd2;
  localparam logic [2:0] REG_SCALE  = 3'd3;
  localparam logic [2:0] REG_FOCAL  = 3'd4;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [17:0] cos_angle;
    logic signed [17:0] sin_angle;
    logic signed [31:0] offset;
    logic signed [31:0] scale;
    logic        [30:0] focal_distance;
  } cfg_t;

  typedef struct packed {
    logic        [3:0]  func;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [64:0] p0;
    logic signed [64:0] p1;
    logic signed [64:0] p2;
    logic signed [64:0] p3;
  } mul_t;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [32:0] rem;
    logic [31:0] lo;
  } lane_t;

  typedef struct packed {
    logic        proj;
    logic        fault;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic [32:0] dmag;
    lane_t       lx;
    lane_t       ly;
  } div_t;

  function automatic logic [31:0] sat32(input logic signed [66:0] v);
    logic [31:0] r;
    if (v > 67'sh0_7fff_ffff) r = S32_MAX;
    else if (v < -67'sh0_8000_0000) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/core/vtu_in_if.sv
`timescale 1ns / 1ps
interface vtu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  func;
  logic [31:0] in_x;
  logic [31:0] in_y;
  logic [31:0] in_z;
  modport source (output valid, func, in_x, in_y, in_z, input ready);
  modport sink (input valid, func, in_x, in_y, in_z, output ready);
endinterface

### rtl/core/vtu_out_if.sv
`timescale 1ns / 1ps
interface vtu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic        div_fault;
  modport source (output valid, out_x, out_y, out_z, div_fault, input ready);
  modport sink (input valid, out_x, out_y, out_z, div_fault, output ready);
endinterface

### rtl/core/vtu_mul.sv
`timescale 1ns / 1ps
module vtu_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [3:0]    func,
  input  logic [31:0]   in_x,
  input  logic [31:0]   in_y,
  input  logic [31:0]   in_z,
  input  vtu_pkg::cfg_t cfg,
  output logic          valid,
  output vtu_pkg::mul_t data
);
  import vtu_pkg::*;

  logic signed [32:0] a0, a1, a2, a3, c33, s33, sc33, f33;
  logic signed [31:0] b0, b1, b2, b3, x, y, z;

  assign x    = signed'(in_x);
  assign y    = signed'(in_y);
  assign z    = signed'(in_z);
  assign c33  = 33'(cfg.cos_angle);
  assign s33  = 33'(cfg.sin_angle);
  assign sc33 = 33'(cfg.scale);
  assign f33  = signed'({2'b00, cfg.focal_distance});

  always_comb begin
    a0 = '0; a1 = '0; a2 = '0; a3 = '0;
    b0 = '0; b1 = '0; b2 = '0; b3 = '0;
    case (func)
      FN_ROTX: begin
        a0 = c33; b0 = y; a1 = s33; b1 = z; a2 = s33; b2 = y; a3 = c33; b3 = z;
      end
      FN_ROTY: begin
        a0 = c33; b0 = x; a1 = s33; b1 = z; a2 = c33; b2 = z; a3 = s33; b3 = x;
      end
      FN_ROTZ: begin
        a0 = c33; b0 = x; a1 = s33; b1 = y; a2 = s33; b2 = x; a3 = c33; b3 = y;
      end
      FN_ZOOM: begin
        a0 = sc33; b0 = x; a1 = sc33; b1 = y; a2 = sc33; b2 = z;
      end
      FN_CENTRAL: begin
        a0 = f33; b0 = x; a1 = f33; b1 = y;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data.func <= func;
      data.x    <= x;
      data.y    <= y;
      data.z    <= z;
      data.p0   <= a0 * b0;
      data.p1   <= a1 * b1;
      data.p2   <= a2 * b2;
      data.p3   <= a3 * b3;
    end
  end
endmodule

### rtl/core/vtu_prep.sv
`timescale 1ns / 1ps
module vtu_prep #(
  parameter int FRAC_BITS = vtu_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  vtu_pkg::mul_t m,
  input  vtu_pkg::cfg_t cfg,
  output logic          valid,
  output vtu_pkg::div_t data
);
  import vtu_pkg::*;

  function automatic logic [31:0] rnd(input logic signed [66:0] v);
    logic signed [66:0] r;
    r = (v + (67'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sat32(r);
  endfunction

  function automatic lane_t mk_lane(input logic signed [64:0] p, input logic c_neg,
                                    input logic c_nz, input logic d_neg,
                                    input logic d_zero, input logic [32:0] dmag);
    lane_t l;
    logic [64:0] mag;
    mag = p[64] ? 65'(-p) : 65'(p);
    l.rem = '0;
    l.lo  = '0;
    if (d_zero) begin
      l.neg = c_neg;
      l.ovf = c_nz;
    end else begin
      l.neg = c_neg ^ d_neg;
      l.ovf = {2'b00, mag[62:32]} >= dmag;
      if (!l.ovf) begin
        l.rem = {2'b00, mag[62:32]};
        l.lo  = mag[31:0];
      end
    end
    return l;
  endfunction

  logic signed [66:0] e0, e1, e2, e3;
  logic signed [32:0] den;
  logic               dzero;
  logic [32:0]        dmag;
  div_t               nx;

  assign e0    = 67'(m.p0);
  assign e1    = 67'(m.p1);
  assign e2    = 67'(m.p2);
  assign e3    = 67'(m.p3);
  assign den   = signed'({2'b00, cfg.focal_distance}) - 33'(m.z);
  assign dzero = (den == '0);

  always_comb begin
    if (dzero) dmag = 33'd1;
    else if (den[32]) dmag = 33'(-den);
    else dmag = 33'(den);
  end

  always_comb begin
    nx.proj  = (m.func == FN_CENTRAL);
    nx.fault = nx.proj && dzero;
    nx.rx    = m.x;
    nx.ry    = m.y;
    nx.rz    = m.z;
    nx.dmag  = dmag;
    nx.lx    = mk_lane(m.p0, m.x[31], m.x != '0, den[32], dzero, dmag);
    nx.ly    = mk_lane(m.p1, m.y[31], m.y != '0, den[32], dzero, dmag);
    case (m.func)
      FN_ROTX: begin
        nx.ry = rnd(e0 - e1);
        nx.rz = rnd(e2 + e3);
      end
      FN_ROTY: begin
        nx.rx = rnd(e0 + e1);
        nx.rz = rnd(e2 - e3);
      end
      FN_ROTZ: begin
        nx.rx = rnd(e0 - e1);
        nx.ry = rnd(e2 + e3);
      end
      FN_MOVEX: nx.rx = sat32(67'(m.x) + 67'(cfg.offset));
      FN_MOVEY: nx.ry = sat32(67'(m.y) + 67'(cfg.offset));
      FN_MOVEZ: nx.rz = sat32(67'(m.z) + 67'(cfg.offset));
      FN_ZOOM: begin
        nx.rx = rnd(e0);
        nx.ry = rnd(e1);
        nx.rz = rnd(e2);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data <= nx;
    end
  end
endmodule

### rtl/core/vtu_div_step.sv
`timescale 1ns / 1ps
module vtu_div_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  vtu_pkg::div_t d_in,
  output logic          valid,
  output vtu_pkg::div_t data
);
  import vtu_pkg::*;

  // One restoring step: the next dividend bit moves into the remainder and
  // the quotient bit moves into the bottom of the low word.
  function automatic lane_t step(input lane_t l, input logic [32:0] dmag);
    lane_t       r;
    logic [33:0] t;
    logic        ge;
    t     = {l.rem, l.lo[31]};
    ge    = t >= {1'b0, dmag};
    r     = l;
    r.rem = ge ? 33'(t - {1'b0, dmag}) : t[32:0];
    r.lo  = {l.lo[30:0], ge};
    return r;
  endfunction

  div_t nx;

  always_comb begin
    nx    = d_in;
    nx.lx = step(d_in.lx, d_in.dmag);
    nx.ly = step(d_in.ly, d_in.dmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data <= nx;
    end
  end
endmodule

### rtl/core/vtu_out.sv
`timescale 1ns / 1ps
module vtu_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  vtu_pkg::div_t d_in,
  output logic          valid,
  output logic [31:0]   out_x,
  output logic [31:0]   out_y,
  output logic [31:0]   out_z,
  output logic          div_fault
);
  import vtu_pkg::*;

  function automatic logic [31:0] fin(input lane_t l);
    logic [31:0] r;
    if (l.ovf) r = l.neg ? S32_MIN : S32_MAX;
    else if (!l.neg) r = l.lo[31] ? S32_MAX : l.lo;
    else if (l.lo > 32'h8000_0000) r = S32_MIN;
    else r = 32'd0 - l.lo;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x     <= d_in.proj ? fin(d_in.lx) : d_in.rx;
      out_y     <= d_in.proj ? fin(d_in.ly) : d_in.ry;
      out_z     <= d_in.rz;
      div_fault <= d_in.fault;
    end
  end
endmodule

### rtl/core/vertex_transform_unit.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; the two 32-step quotient pipelines for
// central projection set the depth, each stage stalls only when full.
// Reset (rst, synchronous, active high) empties the pipeline and loads the
// registers with cos 1.0, sin 0, offset 0, scale 1.0 and focal distance 10.0.
module vertex_transform_unit #(
  parameter int FRAC_BITS = vtu_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  vtu_in_if.sink      in_ch,
  vtu_out_if.source   out_ch
);
  import vtu_pkg::*;

  cfg_t                  cfg;
  logic [NUM_STAGES:0]   adv;
  logic [NUM_STAGES-1:0] vld;
  mul_t                  mdat;
  div_t                  dd [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_angle      <= 18'(1 << FRAC_BITS);
      cfg.sin_angle      <= '0;
      cfg.offset         <= '0;
      cfg.scale          <= 32'(1 << FRAC_BITS);
      cfg.focal_distance <= 31'(10 << FRAC_BITS);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_COS:    cfg.cos_angle      <= cfg_data[17:0];
        REG_SIN:    cfg.sin_angle      <= cfg_data[17:0];
        REG_OFFSET: cfg.offset         <= cfg_data;
        REG_SCALE:  cfg.scale          <= cfg_data;
        REG_FOCAL:  cfg.focal_distance <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  // A stage moves on when it is empty or the stage after it moves on.
  always_comb begin
    adv[NUM_STAGES] = out_ch.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ch.ready  = adv[0];
  assign out_ch.valid = vld[NUM_STAGES-1];

  vtu_mul u_mul (
    .clk(clk), .rst(rst), .adv(adv[0]), .in_valid(in_ch.valid),
    .func(in_ch.func), .in_x(in_ch.in_x), .in_y(in_ch.in_y), .in_z(in_ch.in_z),
    .cfg(cfg), .valid(vld[0]), .data(mdat)
  );

  vtu_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk(clk), .rst(rst), .adv(adv[1]), .in_valid(vld[0]), .m(mdat),
    .cfg(cfg), .valid(vld[1]), .data(dd[0])
  );

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    vtu_div_step u_step (
      .clk(clk), .rst(rst), .adv(adv[j+2]), .in_valid(vld[j+1]),
      .d_in(dd[j]), .valid(vld[j+2]), .data(dd[j+1])
    );
  end

  vtu_out u_out (
    .clk(clk), .rst(rst), .adv(adv[NUM_STAGES-1]), .in_valid(vld[NUM_STAGES-2]),
    .d_in(dd[DIV_STEPS]), .valid(vld[NUM_STAGES-1]),
    .out_x(out_ch.out_x), .out_y(out_ch.out_y), .out_z(out_ch.out_z),
    .div_fault(out_ch.div_fault)
  );
endmodule
